// ===== hw/rtl/watermark_backpressure_fifo_unit_defines.svh =====
// Assertion macros for the watermark backpressure FIFO.
`ifndef WATERMARK_BACKPRESSURE_FIFO_UNIT_DEFINES_SVH
`define WATERMARK_BACKPRESSURE_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define WBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define WBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wbf_pkg.sv =====
// Shared types and constants for the watermark backpressure FIFO.
package wbf_pkg;

    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] HIGH_WATER_RESET   = 7'd64;
    localparam logic [CFG_W-1:0] RESUME_LEVEL_RESET = 7'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_WATER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESUME_LEVEL = 2'd1;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Command broadcast to every storage cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/wbf_cell.sv =====
// One storage cell of the shifting FIFO chain.
module wbf_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  wbf_pkg::t_cell_cmd    i_cmd,
    input  logic                  i_tail,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // pop moves every word one cell towards the head; push fills the tail cell
    always_comb begin
        n_data = r_data;
        if (i_cmd.pop) begin
            n_data = i_next_data;
        end else if (i_cmd.push && i_tail) begin
            n_data = i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/watermark_backpressure_fifo_unit.sv =====
// Top level: shifting FIFO with high/low watermark backpressure.
// The result beat of an accepted beat is registered and follows in the next cycle.
// One push or pop per cycle unless stalled; the result register frees as it drains.
// Storage is a chain of DEPTH cells; a pop shifts the whole chain one place.
// Reset clears occupancy, backpressure and result valid, and loads the watermark
// registers with their reset values; stored words are not cleared.
module watermark_backpressure_fifo_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wbf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wbf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [DATA_WIDTH-1:0]       i_data_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_accepted,
    output logic [DATA_WIDTH-1:0]       o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]  o_occupancy,
    output logic                        o_pressure_flag,
    output logic                        o_high_event,
    output logic                        o_low_event
);

`include "watermark_backpressure_fifo_unit_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > wbf_pkg::CFG_W) ? CNT_W : wbf_pkg::CFG_W;

    logic [wbf_pkg::CFG_W-1:0] r_high_water;
    logic [wbf_pkg::CFG_W-1:0] r_resume_level;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_press;
    logic                      n_press;

    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_acc;
    logic [DATA_WIDTH-1:0]     r_data;
    logic [CNT_W-1:0]          r_occ;
    logic                      r_flag;
    logic                      r_hi;
    logic                      r_lo;

    logic                      in_acc;
    logic                      push_ok;
    logic                      pop_ok;
    logic                      hi_ev;
    logic                      lo_ev;
    logic [CNT_W-1:0]          cnt_inc;
    logic [CNT_W-1:0]          cnt_dec;
    logic [CMP_W-1:0]          hw_ext;
    logic [CMP_W-1:0]          hw_eff;
    wbf_pkg::t_cell_cmd        cmd;
    logic [DATA_WIDTH-1:0]     cell_q [DEPTH];
    logic [DATA_WIDTH-1:0]     head_data;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water   <= wbf_pkg::HIGH_WATER_RESET;
            r_resume_level <= wbf_pkg::RESUME_LEVEL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wbf_pkg::CFG_IDX_HIGH_WATER) begin
                r_high_water <= i_cfg_data;
            end else if (i_cfg_idx == wbf_pkg::CFG_IDX_RESUME_LEVEL) begin
                r_resume_level <= i_cfg_data;
            end
        end
    end

    // ---------------- operation decode ----------------
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign hw_ext  = CMP_W'(r_high_water);
    assign hw_eff  = (hw_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : hw_ext;
    assign cnt_inc = r_count + CNT_W'(1);
    assign cnt_dec = r_count - CNT_W'(1);

    assign push_ok = in_acc && (i_kind == wbf_pkg::KIND_PUSH) && !r_press
                     && (CMP_W'(r_count) < CMP_W'(DEPTH));
    assign pop_ok  = in_acc && (i_kind == wbf_pkg::KIND_POP) && (r_count != '0);
    assign hi_ev   = push_ok && (CMP_W'(cnt_inc) >= hw_eff);
    assign lo_ev   = pop_ok && r_press
                     && (CMP_W'(cnt_dec) <= CMP_W'(r_resume_level));

    always_comb begin
        n_count = r_count;
        n_press = r_press;
        if (push_ok) begin
            n_count = cnt_inc;
            if (hi_ev) begin
                n_press = 1'b1;
            end
        end else if (pop_ok) begin
            n_count = cnt_dec;
            if (lo_ev) begin
                n_press = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_press <= 1'b0;
        end else begin
            r_count <= n_count;
            r_press <= n_press;
        end
    end

    // ---------------- cell chain ----------------
    assign cmd.push = push_ok;
    assign cmd.pop  = pop_ok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] next_data;
        if (g == DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_q[g+1];
        end

        wbf_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_tail      (r_count == CNT_W'(g)),
            .i_push_data (i_data_in),
            .i_next_data (next_data),
            .o_data      (cell_q[g])
        );
    end

    assign head_data = cell_q[0];

    // ---------------- result register ----------------
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (in_acc) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_acc  <= push_ok || pop_ok;
            r_data <= pop_ok ? head_data : '0;
            r_occ  <= n_count;
            r_flag <= n_press;
            r_hi   <= hi_ev;
            r_lo   <= lo_ev;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_acc;
    assign o_data_out      = r_data;
    assign o_occupancy     = r_occ;
    assign o_pressure_flag = r_flag;
    assign o_high_event    = r_hi;
    assign o_low_event     = r_lo;

    // ---------------- assertions ----------------
    `WBF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, CMP_W'(r_count) <= CMP_W'(DEPTH), "occupancy above depth")
    `WBF_ASSERT_NOW(a_press_nonempty, i_clk, i_rst_n, r_press, r_count != '0, "backpressure with empty queue")
    `WBF_ASSERT_NOW(a_hi_sets_flag, i_clk, i_rst_n, r_out_valid && r_hi, r_flag && r_acc && !r_lo, "high event without flag")
    `WBF_ASSERT_NEXT(a_beat_result, i_clk, i_rst_n, in_acc, r_out_valid && (r_occ == r_count), "result beat missing")

endmodule
